// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

	// Operation codes carried with each beat.
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MAG = 3'd4
	} op_t;

	// Control word that travels beside the data through every stage.
	typedef struct packed {
		logic valid;
		op_t  op;
		logic dz;
		logic ovf_re;
		logic ovf_im;
		logic neg_re;
		logic neg_im;
	} ctl_t;

endpackage

// ===== hw/rtl/cau_cell.sv =====
module cau_cell
	import cau_pkg::*;
#(
	parameter int W = 32,
	parameter int K = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic [3*W-1:0]    r_re,
	input  logic [3*W-1:0]    r_im,
	input  logic [3*W-1:0]    d,
	input  logic [W-1:0]      q_re,
	input  logic [W-1:0]      q_im,
	input  logic [2*W-1:0]    sx,
	input  logic [2*W-1:0]    sr,
	output ctl_t              ctl_next,
	output logic [3*W-1:0]    r_re_next,
	output logic [3*W-1:0]    r_im_next,
	output logic [3*W-1:0]    d_next,
	output logic [W-1:0]      q_re_next,
	output logic [W-1:0]      q_im_next,
	output logic [2*W-1:0]    sx_next,
	output logic [2*W-1:0]    sr_next
);

	localparam int PW = 2 * W;
	localparam int RW = 3 * W;
	localparam logic [PW-1:0] SQ_BIT = PW'(1) << (PW - 2 - 2 * K);

	ctl_t          ctl_q;
	logic [RW-1:0] r_re_q, r_im_q, d_q;
	logic [W-1:0]  q_re_q, q_im_q;
	logic [PW-1:0] sx_q, sr_q;

	logic          ge_re, ge_im, ge_sq;
	logic [RW-1:0] nr_re, nr_im;
	logic [PW-1:0] trial;

	// One restoring divide step per part, and one square root digit.
	always_comb begin
		ge_re = (r_re >= d);
		ge_im = (r_im >= d);
		nr_re = ge_re ? (r_re - d) : r_re;
		nr_im = ge_im ? (r_im - d) : r_im;
		trial = sr + SQ_BIT;
		ge_sq = (sx >= trial);
	end

	// Control state of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl;
		end
	end

	// Data handed to the next cell; only the active operation changes it.
	always_ff @(posedge clk) begin
		d_q <= d;
		if (ctl.op == OP_DIV) begin
			r_re_q <= nr_re << 1;
			r_im_q <= nr_im << 1;
			q_re_q <= {q_re[W-2:0], ge_re};
			q_im_q <= {q_im[W-2:0], ge_im};
		end else begin
			r_re_q <= r_re;
			r_im_q <= r_im;
			q_re_q <= q_re;
			q_im_q <= q_im;
		end
		if (ctl.op == OP_MAG && ge_sq) begin
			sx_q <= sx - trial;
			sr_q <= (sr >> 1) + SQ_BIT;
		end else if (ctl.op == OP_MAG) begin
			sx_q <= sx;
			sr_q <= sr >> 1;
		end else begin
			sx_q <= sx;
			sr_q <= sr;
		end
	end

	assign ctl_next  = ctl_q;
	assign r_re_next = r_re_q;
	assign r_im_next = r_im_q;
	assign d_next    = d_q;
	assign q_re_next = q_re_q;
	assign q_im_next = q_im_q;
	assign sx_next   = sx_q;
	assign sr_next   = sr_q;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit on signed fixed point words (Q16.16 by default).
// Input channel: an operation code and two complex operands are taken as one
// beat at a rising edge where start is high and busy is low. busy stays low,
// so a new beat may enter on every cycle.
// Operations: add, subtract, multiply, divide (a * conj(b) / |b|^2) and the
// magnitude of a. Multiply, divide and magnitude truncate toward zero.
// Output channel: each result beat shows for one cycle with done high; the
// receiver cannot stall, so results must be taken when they appear.
// From accept to done a beat passes the multiply front end, the row of
// WORD_BITS cells, each producing one quotient bit of both divide parts and
// one square root digit, and the saturation stage. Throughput is one beat
// per cycle for every operation. Results saturate to the word range and
// raise overflow. A zero denominator gives a zero result with divide_by_zero.
// Unused codes give zero, no flags. Reset clears all valid bits; beats in
// flight at reset are dropped.
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic signed [31:0] a_real,
	input  logic signed [31:0] a_imag,
	input  logic signed [31:0] b_real,
	input  logic signed [31:0] b_imag,
	output logic               done,
	output logic signed [31:0] result_real,
	output logic signed [31:0] result_imag,
	output logic               divide_by_zero,
	output logic               overflow
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int PW = 2 * W;
	localparam int RW = 3 * W;
	localparam int XW = 3 * W + F;

	// Saturate a magnitude with sign to W bits; top bit is the clip flag.
	function automatic logic [W:0] sat(input logic [PW-1:0] m, input logic neg);
		logic [PW-1:0] lim;
		logic [PW-1:0] mc;
		logic          clip;
		logic [W-1:0]  v;
		lim  = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
		clip = (m > lim);
		mc   = clip ? lim : m;
		v    = neg ? (~mc[W-1:0] + 1'b1) : mc[W-1:0];
		return {clip, v};
	endfunction

	assign busy = 1'b0;

	// Stage 1: register the beat, pick the operands of the squaring units.
	ctl_t                ctl_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1, x1_s1, x2_s1;
	ctl_t                ctl_in;

	always_comb begin
		ctl_in       = '0;
		ctl_in.valid = start;
		ctl_in.op    = op_t'(operation);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		ar_s1 <= W'(a_real);
		ai_s1 <= W'(a_imag);
		br_s1 <= W'(b_real);
		bi_s1 <= W'(b_imag);
		x1_s1 <= (op_t'(operation) == OP_MAG) ? W'(a_real) : W'(b_real);
		x2_s1 <= (op_t'(operation) == OP_MAG) ? W'(a_imag) : W'(b_imag);
	end

	// Stage 2: the products, and the sum or difference for add and subtract.
	ctl_t                 ctl_s2;
	logic signed [PW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sq1_s2, sq2_s2;
	logic signed [W:0]    as_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prr_s2 <= PW'(ar_s1) * PW'(br_s1);
		pii_s2 <= PW'(ai_s1) * PW'(bi_s1);
		pri_s2 <= PW'(ar_s1) * PW'(bi_s1);
		pir_s2 <= PW'(ai_s1) * PW'(br_s1);
		sq1_s2 <= PW'(x1_s1) * PW'(x1_s1);
		sq2_s2 <= PW'(x2_s1) * PW'(x2_s1);
		if (ctl_s1.op == OP_SUB) begin
			as_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
		end else begin
			as_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
		end
	end

	// Stage 3: combine products into the two signed parts and the square sum.
	ctl_t                 ctl_s3;
	logic signed [PW:0]   vre_s3, vim_s3;
	logic [PW-1:0]        sqs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqs_s3 <= PW'($unsigned(sq1_s2)) + PW'($unsigned(sq2_s2));
		case (ctl_s2.op)
			OP_ADD, OP_SUB: begin
				vre_s3 <= (PW+1)'(as_s2);
				vim_s3 <= '0;
			end
			OP_MUL: begin
				vre_s3 <= (PW+1)'(prr_s2) - (PW+1)'(pii_s2);
				vim_s3 <= (PW+1)'(pri_s2) + (PW+1)'(pir_s2);
			end
			OP_DIV: begin
				vre_s3 <= (PW+1)'(prr_s2) + (PW+1)'(pii_s2);
				vim_s3 <= (PW+1)'(pir_s2) - (PW+1)'(pri_s2);
			end
			default: begin
				vre_s3 <= '0;
				vim_s3 <= '0;
			end
		endcase
	end

	// Add and subtract need a second part too; rebuild it from the operands.
	logic signed [W:0] asi_s2;
	logic signed [PW:0] asi_s3;

	always_ff @(posedge clk) begin
		if (ctl_s1.op == OP_SUB) begin
			asi_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
		end else begin
			asi_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
		end
		asi_s3 <= (PW+1)'(asi_s2);
	end

	// Stage 4: magnitudes, divide set-up and range check, feed the cell row.
	logic [PW:0]   mre, mim;
	logic [PW-1:0] mre_w, mim_w;
	logic [XW-1:0] num_re, num_im, den_top;
	ctl_t          ctl_set;
	logic [RW-1:0] r_re_set, r_im_set, d_set;
	logic signed [PW:0] vim_sel;

	always_comb begin
		vim_sel = (ctl_s3.op == OP_ADD || ctl_s3.op == OP_SUB) ? asi_s3 : vim_s3;
		mre     = vre_s3[PW] ? (~vre_s3 + 1'b1) : vre_s3;
		mim     = vim_sel[PW] ? (~vim_sel + 1'b1) : vim_sel;
		mre_w   = mre[PW-1:0];
		mim_w   = mim[PW-1:0];
		num_re  = XW'(mre_w) << F;
		num_im  = XW'(mim_w) << F;
		den_top = XW'(sqs_s3) << W;
		d_set   = RW'(sqs_s3) << (W - 1);

		ctl_set        = ctl_s3;
		ctl_set.neg_re = vre_s3[PW];
		ctl_set.neg_im = vim_sel[PW];
		ctl_set.dz     = 1'b0;
		ctl_set.ovf_re = 1'b0;
		ctl_set.ovf_im = 1'b0;
		r_re_set       = RW'(mre_w);
		r_im_set       = RW'(mim_w);
		case (ctl_s3.op)
			OP_MUL: begin
				r_re_set = RW'(mre_w >> F);
				r_im_set = RW'(mim_w >> F);
			end
			OP_DIV: begin
				ctl_set.dz     = (sqs_s3 == '0);
				ctl_set.ovf_re = (num_re >= den_top);
				ctl_set.ovf_im = (num_im >= den_top);
				r_re_set       = ctl_set.ovf_re ? '0 : num_re[RW-1:0];
				r_im_set       = ctl_set.ovf_im ? '0 : num_im[RW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Connections along the cell row.
	ctl_t          ctl_c  [0:W];
	logic [RW-1:0] r_re_c [0:W];
	logic [RW-1:0] r_im_c [0:W];
	logic [RW-1:0] d_c    [0:W];
	logic [W-1:0]  q_re_c [0:W];
	logic [W-1:0]  q_im_c [0:W];
	logic [PW-1:0] sx_c   [0:W];
	logic [PW-1:0] sr_c   [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else begin
			ctl_c[0] <= ctl_set;
		end
	end

	always_ff @(posedge clk) begin
		r_re_c[0] <= r_re_set;
		r_im_c[0] <= r_im_set;
		d_c[0]    <= d_set;
		q_re_c[0] <= '0;
		q_im_c[0] <= '0;
		sx_c[0]   <= sqs_s3;
		sr_c[0]   <= '0;
	end

	// The row: one quotient bit per divide part and one root digit per cell.
	for (genvar k = 0; k < W; k++) begin : g_cell
		cau_cell #(
			.W (W),
			.K (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl_c[k]),
			.r_re      (r_re_c[k]),
			.r_im      (r_im_c[k]),
			.d         (d_c[k]),
			.q_re      (q_re_c[k]),
			.q_im      (q_im_c[k]),
			.sx        (sx_c[k]),
			.sr        (sr_c[k]),
			.ctl_next  (ctl_c[k+1]),
			.r_re_next (r_re_c[k+1]),
			.r_im_next (r_im_c[k+1]),
			.d_next    (d_c[k+1]),
			.q_re_next (q_re_c[k+1]),
			.q_im_next (q_im_c[k+1]),
			.sx_next   (sx_c[k+1]),
			.sr_next   (sr_c[k+1])
		);
	end

	// Final stage: pick the magnitude, saturate, and present the beat.
	ctl_t          ctl_e;
	logic [PW-1:0] fm_re, fm_im;
	logic          fneg_re, fneg_im;
	logic [W:0]    sat_re, sat_im;
	logic          op_ok;

	always_comb begin
		ctl_e   = ctl_c[W];
		fneg_re = ctl_e.neg_re;
		fneg_im = ctl_e.neg_im;
		fm_re   = r_re_c[W][PW-1:0];
		fm_im   = r_im_c[W][PW-1:0];
		op_ok   = 1'b1;
		case (ctl_e.op)
			OP_ADD, OP_SUB, OP_MUL: begin
			end
			OP_DIV: begin
				fm_re = ctl_e.ovf_re ? '1 : PW'(q_re_c[W]);
				fm_im = ctl_e.ovf_im ? '1 : PW'(q_im_c[W]);
			end
			OP_MAG: begin
				fm_re   = sr_c[W];
				fm_im   = '0;
				fneg_re = 1'b0;
				fneg_im = 1'b0;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
		sat_re = sat(fm_re, fneg_re);
		sat_im = sat(fm_im, fneg_im);
	end

	logic                done_q, dz_q, ovf_q;
	logic signed [W-1:0] res_re_q, res_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!op_ok || ctl_e.dz) begin
			res_re_q <= '0;
			res_im_q <= '0;
			ovf_q    <= 1'b0;
		end else begin
			res_re_q <= sat_re[W-1:0];
			res_im_q <= sat_im[W-1:0];
			ovf_q    <= sat_re[W] | sat_im[W];
		end
		dz_q <= op_ok & ctl_e.dz;
	end

	assign done           = done_q;
	assign result_real    = 32'(res_re_q);
	assign result_imag    = 32'(res_im_q);
	assign divide_by_zero = dz_q;
	assign overflow       = ovf_q;

	// Every accepted beat comes out on done after it has passed the whole pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(W + 5) done)
		else $error("result beat missing after fixed latency");

	// A zero denominator never reports saturation and always gives zero.
	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> (!overflow && result_real == 0 && result_imag == 0))
		else $error("divide by zero beat carries data or overflow");

	// A magnitude has no imaginary part and is never negative.
	a_mag_form: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_e.valid && ctl_e.op == OP_MAG |=> (result_imag == 0 && !result_real[31]))
		else $error("magnitude beat malformed");

endmodule
